@@ rtl/core/fmc_pkg.sv @@
`default_nettype none

package fmc_pkg;

	// Queue geometry.
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// Fill counter holds 0..DEPTH and is never narrower than the count port.
	localparam int CNT_W = ($clog2(DEPTH + 1) > 5) ? $clog2(DEPTH + 1) : 5;

	// Command codes.
	typedef enum logic [2:0] {
		CMD_ENQ        = 3'd0,
		CMD_ENQ_UNIQUE = 3'd1,
		CMD_DEQ        = 3'd2,
		CMD_QUERY      = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	// Status codes.
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL  = 3'd2,
		ST_NULL  = 3'd3,
		ST_DUP   = 3'd4
	} status_t;

	typedef logic [DATA_WIDTH-1:0] data_t;

	// Per-cell control from the queue controller.
	typedef struct packed {
		logic shift;
		logic load;
		logic held;
	} cell_ctl_t;

	// Take the low DATA_WIDTH bits of a port value, zero-extending if wider.
	function automatic data_t to_data(logic [31:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	// Bring a stored value back to the 32-bit port width.
	function automatic logic [31:0] from_data(data_t d);
		logic [63:0] w;
		w = 64'(d);
		return w[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/fmc_cell.sv @@
`default_nettype none

module fmc_cell import fmc_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire data_t     next_data,
	input  wire data_t     wr_data,
	input  wire data_t     key,
	output      data_t     data,
	output      logic      match
);

	data_t data_q;

	// A dequeue moves every entry one cell toward the head; an enqueue
	// writes the cell just past the youngest entry.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= next_data;
		end else if (ctl.load) begin
			data_q <= wr_data;
		end
	end

	// Only a held entry takes part in the membership compare.
	assign match = ctl.held && (data_q == key);
	assign data  = data_q;

endmodule

`default_nettype wire

@@ rtl/core/fifo_with_membership_check.sv @@
// Channel   Ports                              Transfer
// command   start, busy, cmd, value            start high while busy low
// result    done, status, value_out, found,    done high for one cycle
//           count
//
// Every command's result is registered and appears with done on the cycle
// after the command transfer, and busy stays low, so one command per cycle.
// The compare of a query or a unique enqueue runs across all cells at once.
// After arst_n is released the queue is empty and the next command is taken.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module fifo_with_membership_check import fmc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [31:0] value,
	output      logic        done,
	output      logic [2:0]  status,
	output      logic [31:0] value_out,
	output      logic        found,
	output      logic [4:0]  count
);

	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q;
	status_t          status_q, status_d;
	logic [31:0]      value_out_q, value_out_d;
	logic             found_q, found_d;

	data_t            key;
	data_t            cell_data [DEPTH];
	logic [DEPTH-1:0] cell_match;
	cell_ctl_t        cell_ctl [DEPTH];
	logic             shift_en, load_en;
	logic             is_null, is_full, is_empty, any_match;

	assign key       = to_data(value);
	assign is_null   = (key == '0);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign any_match = |cell_match;

	// Row of storage cells; the head entry sits in cell zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t next_data;
		if (i == DEPTH - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		assign cell_ctl[i].shift = shift_en;
		assign cell_ctl[i].load  = load_en && (count_q == CNT_W'(i));
		assign cell_ctl[i].held  = (count_q > CNT_W'(i));

		fmc_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.next_data (next_data),
			.wr_data   (key),
			.key       (key),
			.data      (cell_data[i]),
			.match     (cell_match[i])
		);
	end

	// Command decode: status, fill count, dequeued value, query hit and cell controls.
	always_comb begin
		shift_en    = 1'b0;
		load_en     = 1'b0;
		count_d     = count_q;
		status_d    = ST_OK;
		value_out_d = '0;
		found_d     = 1'b0;
		if (start) begin
			unique case (cmd_t'(cmd))
				CMD_ENQ: begin
					if (is_null) begin
						status_d = ST_NULL;
					end else if (is_full) begin
						status_d = ST_FULL;
					end else begin
						load_en = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_ENQ_UNIQUE: begin
					if (is_null) begin
						status_d = ST_NULL;
					end else if (any_match) begin
						status_d = ST_DUP;
					end else if (is_full) begin
						status_d = ST_FULL;
					end else begin
						load_en = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_DEQ: begin
					if (is_empty) begin
						status_d = ST_EMPTY;
					end else begin
						shift_en    = 1'b1;
						value_out_d = from_data(cell_data[0]);
						count_d     = count_q - CNT_W'(1);
					end
				end
				CMD_QUERY: begin
					if (is_null) begin
						status_d = ST_NULL;
					end else begin
						found_d = any_match;
					end
				end
				CMD_CLEAR: begin
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Control state: fill count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= start;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		status_q    <= status_d;
		value_out_q <= value_out_d;
		found_q     <= found_d;
	end

	assign busy      = 1'b0;
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;
	assign found     = found_q;
	assign count     = count_q[4:0];

	// The fill count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// Every command transfer gives a result on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("missing result after command");

	// A full report only comes with a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q == ST_FULL) |-> (count_q == CNT_W'(DEPTH)))
		else $error("full status with room left");

	// A hit needs at least one held entry.
	a_found_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && found_q |-> (count_q != '0) && (status_q == ST_OK))
		else $error("found reported on empty queue");

endmodule

`default_nettype wire

@@ tb/sv/tb_fifo_with_membership_check.sv @@
module tb_fifo_with_membership_check;
	import fmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Command codes that the block leaves unused.
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		status_t     status;
		logic [31:0] value_out;
		logic        found;
		logic [4:0]  count;
	} result_t;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] val;
		int          reps;
		bit          fixed;
		result_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [31:0] value;
	logic        done;
	logic [2:0]  status;
	logic [31:0] value_out;
	logic        found;
	logic [4:0]  count;

	// Shadow copy of the queue contents.
	data_t ring_data [DEPTH];
	int    ring_head;
	int    ring_tail;
	int    ring_fill;

	result_t   pending_results [$];
	stim_row_t stim_rows [$];
	int        errors;
	int        stall_cycles;
	bit        idle_on;

	fifo_with_membership_check u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.value     (value),
		.done      (done),
		.status    (status),
		.value_out (value_out),
		.found     (found),
		.count     (count)
	);

	// Free-running clock.
	always #5 clk = ~clk;

	// Empty the shadow queue, as after reset or a clear command.
	function automatic void clear_ring();
		for (int i = 0; i < DEPTH; i++) begin
			ring_data[i] = '0;
		end
		ring_head = 0;
		ring_tail = 0;
		ring_fill = 0;
	endfunction

	// Search every held entry for a value.
	function automatic bit ring_holds(data_t v);
		int p;
		p = ring_head;
		for (int k = 0; k < ring_fill; k++) begin
			if (ring_data[p] == v)
				return 1'b1;
			p = (p + 1) % DEPTH;
		end
		return 1'b0;
	endfunction

	// Apply one command to the shadow queue and return the result it should give.
	function automatic result_t queue_outcome(logic [2:0] c, logic [31:0] raw);
		result_t r;
		data_t   v;
		v = data_t'(raw);
		r.status    = ST_OK;
		r.value_out = '0;
		r.found     = 1'b0;
		case (c)
			CMD_ENQ, CMD_ENQ_UNIQUE: begin
				if (v == '0)
					r.status = ST_NULL;
				else if (c == CMD_ENQ_UNIQUE && ring_holds(v))
					r.status = ST_DUP;
				else if (ring_fill >= DEPTH)
					r.status = ST_FULL;
				else begin
					ring_data[ring_tail] = v;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_fill++;
				end
			end
			CMD_DEQ: begin
				if (ring_fill == 0)
					r.status = ST_EMPTY;
				else begin
					r.value_out = 32'(ring_data[ring_head]);
					ring_data[ring_head] = '0;
					ring_fill--;
					// The pointers snap back to slot zero when the queue runs dry.
					if (ring_fill == 0) begin
						ring_head = 0;
						ring_tail = 0;
					end else begin
						ring_head = (ring_head + 1) % DEPTH;
					end
				end
			end
			CMD_QUERY: begin
				if (v == '0)
					r.status = ST_NULL;
				else
					r.found = ring_holds(v);
			end
			CMD_CLEAR: begin
				clear_ring();
			end
			default: begin
			end
		endcase
		r.count = 5'(ring_fill);
		return r;
	endfunction

	// Table rows checked against the shadow queue.
	function automatic void add_row(logic [2:0] op, logic [31:0] val, int reps);
		stim_row_t row;
		row.op    = op;
		row.val   = val;
		row.reps  = reps;
		row.fixed = 1'b0;
		row.want  = '0;
		stim_rows.push_back(row);
	endfunction

	// Table rows with the expected result written out.
	function automatic void add_fixed(logic [2:0] op, logic [31:0] val, status_t st,
			logic [31:0] vout, logic fnd, logic [4:0] cnt);
		stim_row_t row;
		row.op             = op;
		row.val            = val;
		row.reps           = 1;
		row.fixed          = 1'b1;
		row.want.status    = st;
		row.want.value_out = vout;
		row.want.found     = fnd;
		row.want.count     = cnt;
		stim_rows.push_back(row);
	endfunction

	// Random command, leaning toward filling or draining the queue.
	function automatic logic [2:0] pick_cmd(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return CMD_CLEAR;
		if (r < 5)
			return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		if (r < 27)
			return CMD_QUERY;
		if (filling) begin
			if (r < 40)
				return CMD_DEQ;
			if (r < 65)
				return CMD_ENQ_UNIQUE;
			return CMD_ENQ;
		end
		if (r < 75)
			return CMD_DEQ;
		if (r < 87)
			return CMD_ENQ_UNIQUE;
		return CMD_ENQ;
	endfunction

	// Random value: null, a held entry, a small repeated value, or any word.
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 40 && ring_fill > 0)
			return 32'(ring_data[(ring_head + $urandom_range(0, ring_fill - 1)) % DEPTH]);
		if (r < 75)
			return 32'($urandom_range(1, 24));
		return $urandom;
	endfunction

	// Offer one command, wait for its transfer, then record what it should return.
	task automatic issue_command(logic [2:0] c, logic [31:0] v, bit fixed, result_t want);
		result_t r;
		@(negedge clk);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 17) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		cmd   <= c;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		r = queue_outcome(c, v);
		pending_results.push_back(fixed ? want : r);
	endtask

	// Hold the command side off until every outstanding result is back.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Result checking and the stall watchdog.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none actual %h %h %h %h",
						$time, status, value_out, found, count);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("value_out", want.value_out, value_out);
					check_field("found", 32'(want.found), 32'(found));
					check_field("count", 32'(want.count), 32'(count));
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL fifo_with_membership_check");
				$finish;
			end
		end
	end

	initial begin
		bit          filling;
		int          phase_left;
		logic [2:0]  c;
		logic [31:0] v;

		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_ENQ;
		value        = '0;
		errors       = 0;
		stall_cycles = 0;
		idle_on      = 1'b1;
		clear_ring();

		// Directed table: empty cases, nulls, extremes, duplicates, full and clear.
		add_fixed(CMD_DEQ, 32'h0, ST_EMPTY, 32'h0, 1'b0, 5'd0);
		add_fixed(CMD_QUERY, 32'h1234, ST_OK, 32'h0, 1'b0, 5'd0);
		add_fixed(CMD_ENQ, 32'h0, ST_NULL, 32'h0, 1'b0, 5'd0);
		add_fixed(CMD_ENQ_UNIQUE, 32'h0, ST_NULL, 32'h0, 1'b0, 5'd0);
		add_fixed(CMD_QUERY, 32'h0, ST_NULL, 32'h0, 1'b0, 5'd0);
		add_fixed(CMD_ENQ, 32'hFFFF_FFFF, ST_OK, 32'h0, 1'b0, 5'd1);
		add_fixed(CMD_ENQ, 32'h1, ST_OK, 32'h0, 1'b0, 5'd2);
		add_fixed(CMD_ENQ_UNIQUE, 32'h1, ST_DUP, 32'h0, 1'b0, 5'd2);
		add_fixed(CMD_QUERY, 32'hFFFF_FFFF, ST_OK, 32'h0, 1'b1, 5'd2);
		add_row(CMD_QUERY, 32'h8000_0000, 1);
		add_fixed(CMD_DEQ, 32'h0, ST_OK, 32'hFFFF_FFFF, 1'b0, 5'd1);
		add_fixed(CMD_DEQ, 32'h0, ST_OK, 32'h1, 1'b0, 5'd0);
		add_row(CMD_ENQ, 32'h5A5A_A5A5, 1);
		add_row(CMD_SPARE_LO, 32'hFFFF_FFFF, 1);
		add_row(3'(CMD_SPARE_LO + 3'd1), 32'h0, 1);
		add_row(CMD_SPARE_HI, 32'h5A5A_A5A5, 1);
		add_fixed(CMD_CLEAR, 32'h0, ST_OK, 32'h0, 1'b0, 5'd0);
		add_row(CMD_ENQ_UNIQUE, 32'h100, DEPTH);
		add_fixed(CMD_ENQ, 32'hDEAD, ST_FULL, 32'h0, 1'b0, 5'(DEPTH));
		add_fixed(CMD_ENQ_UNIQUE, 32'h100, ST_DUP, 32'h0, 1'b0, 5'(DEPTH));
		add_fixed(CMD_ENQ_UNIQUE, 32'h7777, ST_FULL, 32'h0, 1'b0, 5'(DEPTH));
		add_row(CMD_QUERY, 32'h10F, 1);
		add_row(CMD_DEQ, 32'h0, 3);
		add_row(CMD_ENQ, 32'h200, 3);
		add_fixed(CMD_CLEAR, 32'h0, ST_OK, 32'h0, 1'b0, 5'd0);

		// Hold reset, then release it at a falling edge, away from the active edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			for (int k = 0; k < stim_rows[i].reps; k++)
				issue_command(stim_rows[i].op, stim_rows[i].val + 32'(k),
					stim_rows[i].fixed, stim_rows[i].want);
		end
		drain_results();

		// Random traffic in alternating fill and drain phases.
		filling    = 1'b1;
		phase_left = $urandom_range(30, 80);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !(n >= 300 && n < 450);
			if (n == 425)
				drain_results();
			if (phase_left == 0) begin
				filling    = !filling;
				phase_left = $urandom_range(30, 80);
			end
			phase_left--;
			c = pick_cmd(filling);
			v = pick_value();
			issue_command(c, v, 1'b0, '0);
		end

		// Let the last results come back, then a few quiet cycles.
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASS fifo_with_membership_check");
		else
			$display("FAIL fifo_with_membership_check");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/fmc_pkg.sv
rtl/core/fmc_cell.sv
rtl/core/fifo_with_membership_check.sv
tb/sv/tb_fifo_with_membership_check.sv
